// ----- rtl/core/lobm_pkg.sv -----
// Shared types and constants for the limit order book matcher.
// Depends on nothing; every other file of the block imports it.
package lobm_pkg;

    localparam int PRICE_LEVELS = 1024;
    localparam int ADDR_W       = $clog2(PRICE_LEVELS);
    localparam int LEVEL_W      = 32;
    localparam int QTY_W        = 16;
    localparam int TOTAL_W      = 48;
    localparam int PROD_W       = ADDR_W + QTY_W;

    localparam int IN_DATA_W    = 32;
    localparam int OUT_DATA_W   = TOTAL_W + 2 * QTY_W;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = {LEVEL_W{1'b1}};
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
    localparam logic [ADDR_W-1:0]  LAST_LEVEL = ADDR_W'(PRICE_LEVELS - 1);

    localparam logic SIDE_BUY  = 1'b0;
    localparam logic SIDE_SELL = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_REST_RD,
        ST_REST_WR,
        ST_FINISH
    } lobm_state_t;

    typedef struct packed {
        logic clear;
        logic accept;
        logic issue;
        logic rest_rd;
        logic rest_wr;
        logic load_out;
    } lobm_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic scan_end;
        logic want_zero;
        logic pipe_empty;
    } lobm_status_t;

endpackage

// ----- rtl/core/lobm_datapath.sv -----
// Datapath of the limit order book matcher: both level memories, the scan
// pipeline, the value accumulator and the result register. Uses lobm_pkg.
module lobm_datapath
    import lobm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  lobm_cmd_t             cmd,
    output lobm_status_t          status,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    output logic [OUT_DATA_W-1:0] m_tdata
);

    logic [LEVEL_W-1:0] buy_mem  [PRICE_LEVELS];
    logic [LEVEL_W-1:0] sell_mem [PRICE_LEVELS];

    logic [ADDR_W-1:0]     clear_addr_reg, clear_addr_next;
    logic [ADDR_W-1:0]     scan_addr_reg, scan_addr_next;
    logic                  scan_end_reg, scan_end_next;
    logic                  side_reg;
    logic [ADDR_W-1:0]     limit_reg;
    logic [QTY_W-1:0]      want_reg, want_next;
    logic [QTY_W-1:0]      filled_reg, filled_next;
    logic [QTY_W-1:0]      rested_reg, rested_next;
    logic                  rd_valid_reg;
    logic [ADDR_W-1:0]     rd_addr_reg;
    logic                  got_valid_reg;
    logic [QTY_W-1:0]      got_reg;
    logic                  prod_valid_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [TOTAL_W-1:0]    total_reg, total_next;
    logic [LEVEL_W-1:0]    buy_rdata_reg, sell_rdata_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic [ADDR_W-1:0]  raddr;
    logic [LEVEL_W-1:0] opp_data, own_data, got_ext;
    logic               take;
    logic [QTY_W-1:0]   got;
    logic [LEVEL_W:0]   rest_sum;
    logic [LEVEL_W-1:0] rest_data;
    logic               rest_we;
    logic               buy_we, sell_we;
    logic [ADDR_W-1:0]  buy_wa, sell_wa;
    logic [LEVEL_W-1:0] buy_wd, sell_wd;

    // Match stage: one level read comes back per cycle and is consumed here.
    assign opp_data = (side_reg == SIDE_BUY) ? sell_rdata_reg : buy_rdata_reg;
    assign own_data = (side_reg == SIDE_BUY) ? buy_rdata_reg : sell_rdata_reg;
    assign take     = rd_valid_reg && (want_reg != '0) && (opp_data != '0);
    assign got      = (opp_data < LEVEL_W'(want_reg)) ? opp_data[QTY_W-1:0] : want_reg;
    assign got_ext  = LEVEL_W'(got);

    assign rest_sum  = {1'b0, own_data} + (LEVEL_W + 1)'(want_reg);
    assign rest_data = rest_sum[LEVEL_W] ? LEVEL_MAX : rest_sum[LEVEL_W-1:0];
    assign rest_we   = cmd.rest_wr && (want_reg != '0);

    assign raddr = cmd.rest_rd ? limit_reg : scan_addr_reg;

    always_comb
    begin
        buy_we  = cmd.clear || (take && side_reg == SIDE_SELL) ||
                  (rest_we && side_reg == SIDE_BUY);
        sell_we = cmd.clear || (take && side_reg == SIDE_BUY) ||
                  (rest_we && side_reg == SIDE_SELL);
        priority if (cmd.clear)
        begin
            buy_wa  = clear_addr_reg;
            sell_wa = clear_addr_reg;
            buy_wd  = '0;
            sell_wd = '0;
        end
        else if (take)
        begin
            buy_wa  = rd_addr_reg;
            sell_wa = rd_addr_reg;
            buy_wd  = opp_data - got_ext;
            sell_wd = opp_data - got_ext;
        end
        else
        begin
            buy_wa  = limit_reg;
            sell_wa = limit_reg;
            buy_wd  = rest_data;
            sell_wd = rest_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (buy_we)
        begin
            buy_mem[buy_wa] <= buy_wd;
        end
        buy_rdata_reg <= buy_mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (sell_we)
        begin
            sell_mem[sell_wa] <= sell_wd;
        end
        sell_rdata_reg <= sell_mem[raddr];
    end

    always_comb
    begin
        clear_addr_next = cmd.clear ? clear_addr_reg + 1'b1 : clear_addr_reg;
        scan_addr_next  = scan_addr_reg;
        scan_end_next   = scan_end_reg;
        want_next       = want_reg;
        filled_next     = filled_reg;
        rested_next     = rested_reg;
        if (cmd.accept)
        begin
            scan_addr_next = (s_tuser == SIDE_BUY) ? '0 : LAST_LEVEL;
            scan_end_next  = 1'b0;
            want_next      = s_tdata[ADDR_W +: QTY_W];
            filled_next    = '0;
            rested_next    = '0;
        end
        if (cmd.issue)
        begin
            scan_end_next  = (scan_addr_reg == limit_reg);
            scan_addr_next = (side_reg == SIDE_BUY) ? scan_addr_reg + 1'b1
                                                    : scan_addr_reg - 1'b1;
        end
        if (take)
        begin
            want_next   = want_reg - got;
            filled_next = filled_reg + got;
        end
        if (rest_we)
        begin
            rested_next = want_reg;
        end
    end

    // Saturating accumulate; the compare against the headroom avoids a carry out.
    always_comb
    begin
        total_next = total_reg;
        if (prod_valid_reg)
        begin
            if (TOTAL_W'(prod_reg) >= TOTAL_MAX - total_reg)
            begin
                total_next = TOTAL_MAX;
            end
            else
            begin
                total_next = total_reg + TOTAL_W'(prod_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_addr_reg <= '0;
            scan_addr_reg  <= '0;
            scan_end_reg   <= 1'b0;
            rd_valid_reg   <= 1'b0;
            got_valid_reg  <= 1'b0;
            prod_valid_reg <= 1'b0;
            total_reg      <= '0;
        end
        else
        begin
            clear_addr_reg <= clear_addr_next;
            scan_addr_reg  <= scan_addr_next;
            scan_end_reg   <= scan_end_next;
            rd_valid_reg   <= cmd.issue;
            got_valid_reg  <= take;
            prod_valid_reg <= got_valid_reg;
            total_reg      <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            side_reg  <= s_tuser;
            limit_reg <= s_tdata[ADDR_W-1:0];
        end
        want_reg    <= want_next;
        filled_reg  <= filled_next;
        rested_reg  <= rested_next;
        rd_addr_reg <= scan_addr_reg;
        got_reg     <= got;
        prod_reg    <= PROD_W'(limit_reg) * PROD_W'(got_reg);
        if (cmd.load_out)
        begin
            out_data_reg <= {rested_reg, filled_reg, total_reg};
        end
    end

    assign m_tdata = out_data_reg;

    assign status.clear_last = (clear_addr_reg == LAST_LEVEL);
    assign status.scan_end   = scan_end_reg;
    assign status.want_zero  = (want_reg == '0);
    assign status.pipe_empty = !rd_valid_reg && !got_valid_reg && !prod_valid_reg;

endmodule

// ----- rtl/core/lobm_controller.sv -----
// Sequencer of the limit order book matcher: clearing pass, scan, drain,
// rest write-back and result hand-off. Uses lobm_pkg.
module lobm_controller
    import lobm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  lobm_status_t status,
    output lobm_cmd_t    cmd
);

    lobm_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        s_tready     = 1'b0;
        m_valid_next = m_valid_reg && !m_tready;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.scan_end || status.want_zero)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cmd.issue = 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (status.pipe_empty)
                begin
                    state_next = ST_REST_RD;
                end
            end
            ST_REST_RD:
            begin
                cmd.rest_rd = 1'b1;
                state_next  = ST_REST_WR;
            end
            ST_REST_WR:
            begin
                cmd.rest_wr = 1'b1;
                state_next  = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;

endmodule

// ----- rtl/core/limit_order_book_matcher.sv -----
// Top level of the limit order book matcher: joins the sequencer and the datapath.
// Depends on lobm_pkg, lobm_controller and lobm_datapath.
//
//  Channel | Dir | Payload                                       | Transfer when
//  --------+-----+-----------------------------------------------+----------------------
//  s_      | in  | tuser: cmd; tdata: limit_price, amount        | s_tvalid & s_tready
//  m_      | out | tdata: total_value, filled_amount, rested_amt | m_tvalid & m_tready
//
// After reset the block sweeps both level memories to zero, one entry of each per
// cycle, over all 1024 levels; s_tready stays low during that pass.
// After its transfer an order scans the opposite-side levels (1 to 1024 are read),
// drains the match pipeline, reads its own level at the limit price, adds any remainder
// to it and then loads the result register; an order of zero amount reads no level. The scan
// reads one level per cycle through the read port of the opposite memory. The idle state then
// accepts the next order, so a new order is taken only once the last result is loaded.
// The result waits in an output register; while it is not taken the next order is
// already accepted and scanned, and only its final load waits for m_tready.
module limit_order_book_matcher
    import lobm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // Fields from bit 0: limit_price [9:0], amount [25:10], zero fill [31:26].
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // Fields from bit 0: cmd (0 buy, 1 sell).
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // Fields from bit 0: total_value [47:0], filled_amount [63:48],
    // rested_amount [79:64].
    output logic [OUT_DATA_W-1:0] m_tdata
);

    lobm_cmd_t    cmd;
    lobm_status_t status;

    // The sequencer owns the handshakes and steps the datapath one command at a time.
    lobm_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds both books, the running total and the result register.
    lobm_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .status  (status),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tdata (m_tdata)
    );

endmodule

// ----- rtl/core/lobm_checker.sv -----
// Port-level checks for the limit order book matcher, bound to the top level.
// Depends on lobm_pkg.
module lobm_checker
    import lobm_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    logic               seen_reg;
    logic [TOTAL_W-1:0] last_total_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg       <= 1'b0;
            last_total_reg <= '0;
        end
        else if (m_tvalid && m_tready)
        begin
            seen_reg       <= 1'b1;
            last_total_reg <= m_tdata[TOTAL_W-1:0];
        end
    end

    // The running total never decreases from one result to the next.
    a_total_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && seen_reg) |-> (m_tdata[TOTAL_W-1:0] >= last_total_reg))
        else $error("total_value decreased between results");

    // One order at a time: the input closes right after a transfer.
    a_one_order: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while an order is being matched");

    // The clearing pass keeps the input closed when reset is released.
    a_clear_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !s_tready)
        else $error("input ready during the clearing pass");

    // No result is shown while reset is held.
    a_no_result_in_reset: assert property (@(posedge clk)
        !rst_n |-> !m_tvalid)
        else $error("result valid during reset");

    // A stalled result holds its payload.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");

endmodule

bind limit_order_book_matcher lobm_checker u_lobm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- dv/tb.sv -----
// Self-checking testbench for limit_order_book_matcher: drives orders and checks every report.
// A scoreboard class tracks both books and the running trade value.
// Depends on lobm_pkg and the matcher RTL.
module tb;
    import lobm_pkg::*;

    localparam int CYCLE_LIMIT   = 8_000_000;
    localparam int RANDOM_ORDERS = 560;
    localparam int SETTLE_CYCLES = 1100;

    // Packed so that a cast from m_tdata lands total in the low bits.
    typedef struct packed {
        logic [QTY_W-1:0]   rested;
        logic [QTY_W-1:0]   filled;
        logic [TOTAL_W-1:0] total;
    } fill_report_t;

    // Mirrors the bid and ask quantity per price level and the running value.
    class book_tracker;
        bit [LEVEL_W-1:0] bids [PRICE_LEVELS];
        bit [LEVEL_W-1:0] asks [PRICE_LEVELS];
        bit [TOTAL_W-1:0] running_value;
        fill_report_t     pending_reports [$];
        int               mismatches;

        function bit [LEVEL_W-1:0] take(inout bit [LEVEL_W-1:0] level,
                                        inout bit [LEVEL_W-1:0] want);
            bit [LEVEL_W-1:0] got;
            got = (level < want) ? level : want;
            level = level - got;
            want  = want - got;
            return got;
        endfunction

        // The fill is valued at the incoming order's limit, not the level's price.
        function void accrue(bit [ADDR_W-1:0] price, bit [LEVEL_W-1:0] got);
            longint unsigned worth;
            worth = 64'(price);
            worth = worth * got;
            if (worth >= TOTAL_MAX - running_value)
                running_value = TOTAL_MAX;
            else
                running_value = running_value + worth;
        endfunction

        function bit [LEVEL_W-1:0] sat_add(bit [LEVEL_W-1:0] a, bit [LEVEL_W-1:0] b);
            if (b > LEVEL_MAX - a)
                return LEVEL_MAX;
            return a + b;
        endfunction

        function void post_order(logic side, logic [ADDR_W-1:0] price, logic [QTY_W-1:0] qty);
            fill_report_t     r;
            bit [LEVEL_W-1:0] want;
            bit [LEVEL_W-1:0] got;
            bit [LEVEL_W-1:0] filled;
            int               step;
            int               lvl;
            want   = LEVEL_W'(qty);
            filled = 0;
            // Buys walk the asks upward from the bottom; sells walk the bids downward.
            for (step = 0; step < PRICE_LEVELS && want != 0; step++) begin
                lvl = (side == SIDE_BUY) ? step : PRICE_LEVELS - 1 - step;
                if ((side == SIDE_BUY) ? (lvl <= int'(price)) : (lvl >= int'(price))) begin
                    if (side == SIDE_BUY)
                        got = take(asks[lvl], want);
                    else
                        got = take(bids[lvl], want);
                    if (got != 0)
                        accrue(price, got);
                    filled = filled + got;
                end
            end
            if (want != 0) begin
                if (side == SIDE_BUY)
                    bids[price] = sat_add(bids[price], want);
                else
                    asks[price] = sat_add(asks[price], want);
            end
            r.total  = running_value;
            r.filled = filled[QTY_W-1:0];
            r.rested = want[QTY_W-1:0];
            pending_reports.push_back(r);
        endfunction

        function void check_report(logic [OUT_DATA_W-1:0] data);
            fill_report_t expect_r;
            fill_report_t seen;
            seen = data;
            if (pending_reports.size() == 0) begin
                $display("%0t: unexpected report, actual %h", $time, data);
                mismatches++;
                return;
            end
            expect_r = pending_reports.pop_front();
            if (seen.total !== expect_r.total) begin
                $display("%0t: total_value expected %0d actual %0d",
                         $time, expect_r.total, seen.total);
                mismatches++;
            end
            if (seen.filled !== expect_r.filled) begin
                $display("%0t: filled_amount expected %0d actual %0d",
                         $time, expect_r.filled, seen.filled);
                mismatches++;
            end
            if (seen.rested !== expect_r.rested) begin
                $display("%0t: rested_amount expected %0d actual %0d",
                         $time, expect_r.rested, seen.rested);
                mismatches++;
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;

    book_tracker book = new;
    int          cycle_count = 0;
    int          burst_left  = 0;

    limit_order_book_matcher u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            book.check_report(m_tdata);
    end

    // Report side: stretches of steady readiness, random stalls, heavy stalls and toggling.
    initial
    begin
        int mode;
        int span;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 300);
            repeat (span)
            begin
                @(negedge clk);
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= cycle_count[0];
                endcase
            end
        end
    end

    // Orders go out in bursts; between bursts the valid drops for a short or long gap.
    task pace();
        int gap;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 1100) : $urandom_range(1, 20);
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
            burst_left = $urandom_range(0, 30);
        end
    endtask

    task send_order(input logic side, input logic [ADDR_W-1:0] price,
                    input logic [QTY_W-1:0] qty);
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= side;
        s_tdata  <= IN_DATA_W'({qty, price});
        do @(posedge clk); while (s_tready !== 1'b1);
        book.post_order(side, price, qty);
        pace();
    endtask

    task drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (book.pending_reports.size() != 0) @(posedge clk);
    endtask

    initial
    begin
        logic              side;
        logic [ADDR_W-1:0] price;
        logic [QTY_W-1:0]  qty;
        int                pick;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= SIDE_BUY;
        s_tdata  <= '0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // Zero-amount orders on both sides at the price extremes.
        send_order(SIDE_BUY, 10'd0, 16'd0);
        send_order(SIDE_SELL, 10'd1023, 16'd0);
        // Rest a bid, then hit it partially from below.
        send_order(SIDE_BUY, 10'd10, 16'd100);
        send_order(SIDE_SELL, 10'd5, 16'd50);
        // Top-of-book ask swept by a full-size buy whose remainder rests at the top.
        send_order(SIDE_SELL, 10'd1023, 16'd100);
        send_order(SIDE_BUY, 10'd1023, 16'hFFFF);
        // Full-size sells at price zero sweep every bid, skipping empty levels.
        send_order(SIDE_SELL, 10'd0, 16'hFFFF);
        send_order(SIDE_BUY, 10'd0, 16'hFFFF);
        send_order(SIDE_SELL, 10'd0, 16'hFFFF);
        // A buy that walks across several ask levels.
        send_order(SIDE_SELL, 10'd300, 16'd10);
        send_order(SIDE_SELL, 10'd301, 16'd20);
        send_order(SIDE_SELL, 10'd302, 16'd30);
        send_order(SIDE_BUY, 10'd302, 16'd100);
        // Orders that do not cross and simply rest.
        send_order(SIDE_BUY, 10'd299, 16'd5);
        send_order(SIDE_SELL, 10'd302, 16'd1);
        // Alternating bit patterns in price and amount.
        send_order(SIDE_BUY, 10'h2AA, 16'hAAAA);
        send_order(SIDE_SELL, 10'h155, 16'h5555);
        send_order(SIDE_SELL, 10'h2AA, 16'h5555);
        send_order(SIDE_BUY, 10'h155, 16'hAAAA);
        send_order(SIDE_BUY, 10'd512, 16'd1);
        send_order(SIDE_SELL, 10'd511, 16'd1);
        drain();

        // Most orders land in a narrow band so both books stay deep and cross often.
        for (int n = 0; n < RANDOM_ORDERS; n++)
        begin
            side = 1'($urandom_range(0, 1));
            price = ($urandom_range(0, 9) < 7) ? ADDR_W'($urandom_range(480, 560))
                                               : ADDR_W'($urandom_range(0, PRICE_LEVELS - 1));
            pick = $urandom_range(0, 19);
            if (pick == 0)
                qty = '0;
            else if (pick < 3)
                qty = QTY_W'($urandom_range(0, 65535));
            else
                qty = QTY_W'($urandom_range(1, 3000));
            send_order(side, price, qty);
            if (n == RANDOM_ORDERS / 2)
                drain();
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (book.mismatches == 0 && book.pending_reports.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- limit_order_book_matcher.f -----
rtl/core/lobm_pkg.sv
rtl/core/lobm_datapath.sv
rtl/core/lobm_controller.sv
rtl/core/limit_order_book_matcher.sv
rtl/core/lobm_checker.sv
dv/tb.sv
